FILE: rtl/core/qllr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qllr_pkg;

   // table size
   localparam int QLLR_MAX_POINTS = 256;

   // queue depths
   localparam int QLLR_CMD_DEPTH = 2;
   localparam int QLLR_RSP_DEPTH = 4;

   // request op codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DEMAP = 1'b1;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS_PER_SYMBOL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SCALE     = 1'd1;

   localparam logic [3:0]  BPS_RESET   = 4'd4;
   localparam logic [3:0]  BPS_MIN     = 4'd2;
   localparam logic [3:0]  BPS_MAX     = 4'd8;
   localparam logic [15:0] NOISE_RESET = 16'd256;

   // datapath widths
   localparam int SAMPLE_W = 16;
   localparam int LLR_W    = 32;
   localparam int DIST_W   = 33;
   localparam int DIFF_W   = 34;
   localparam int PROD_W   = 51;

   localparam logic [LLR_W-1:0] LLR_POS_SAT = 32'h7FFF_FFFF;
   localparam logic [LLR_W-1:0] LLR_NEG_SAT = 32'h8000_0000;

   typedef struct packed {
      logic                is_demap;
      logic [7:0]          point_index;
      logic [SAMPLE_W-1:0] in_phase;
      logic [SAMPLE_W-1:0] quadrature;
   } qllr_cmd_type;

   typedef struct packed {
      logic [2:0]  nb_m1;
      logic [7:0]  npts_m1;
      logic [15:0] noise_scale;
   } qllr_cfg_type;

   typedef struct packed {
      logic [LLR_W-1:0] llr;
      logic [2:0]       bit_position;
      logic             last;
   } qllr_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/qllr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module qllr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/core/qllr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module qllr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/qllr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module qllr_front import qllr_pkg::*; #(
   parameter int MAX_POINTS = QLLR_MAX_POINTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic                  req_op,
   input  wire logic [7:0]            req_point_index,
   input  wire logic [SAMPLE_W-1:0]   req_in_phase,
   input  wire logic [SAMPLE_W-1:0]   req_quadrature,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       cmd_valid,
   output qllr_cmd_type               cmd,
   input  wire logic                  cmd_take,
   output qllr_cfg_type               cfg
);

   logic [3:0]  bps_ff, bps_in;
   logic [15:0] noise_ff, noise_in;
   logic [3:0]  nb;
   logic [8:0]  npts;
   logic        keep;
   logic        accept;
   logic        cmd_empty;
   qllr_cmd_type new_cmd;
   logic [$bits(qllr_cmd_type)-1:0] cmd_bits;

   // register writes
   always_comb begin
      bps_in   = bps_ff;
      noise_in = noise_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BITS_PER_SYMBOL: bps_in   = csr_wdata[3:0];
            CSR_NOISE_SCALE:     noise_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff   <= BPS_RESET;
         noise_ff <= NOISE_RESET;
      end else begin
         bps_ff   <= bps_in;
         noise_ff <= noise_in;
      end
   end

   // clamp to 2..8 bits
   always_comb begin
      if (bps_ff < BPS_MIN) begin
         nb = BPS_MIN;
      end else if (bps_ff > BPS_MAX) begin
         nb = BPS_MAX;
      end else begin
         nb = bps_ff;
      end
   end

   assign npts            = 9'd1 << nb;
   assign cfg.nb_m1       = 3'(nb - 4'd1);
   assign cfg.npts_m1     = 8'(npts - 9'd1);
   assign cfg.noise_scale = noise_ff;

   // loads beyond the table are dropped here
   assign keep   = (req_op == OP_DEMAP) || (11'(req_point_index) < 11'(MAX_POINTS));
   assign accept = push && !full;

   assign new_cmd.is_demap    = (req_op == OP_DEMAP);
   assign new_cmd.point_index = req_point_index;
   assign new_cmd.in_phase    = req_in_phase;
   assign new_cmd.quadrature  = req_quadrature;

   qllr_fifo #(
      .WIDTH ($bits(qllr_cmd_type)),
      .DEPTH (QLLR_CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (accept && keep),
      .wdata (new_cmd),
      .full  (full),
      .pop   (cmd_take),
      .rdata (cmd_bits),
      .empty (cmd_empty)
   );

   assign cmd       = qllr_cmd_type'(cmd_bits);
   assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

FILE: rtl/core/qllr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module qllr_back import qllr_pkg::*; #(
   parameter int MAX_POINTS = QLLR_MAX_POINTS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   cmd_valid,
   input  wire qllr_cmd_type cmd,
   output logic        cmd_take,
   input  wire qllr_cfg_type cfg,
   input  wire logic   rsp_full,
   output logic        rsp_push,
   output qllr_rsp_type rsp
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int LBL_W = (IDX_W > 8) ? IDX_W : 8;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_LLR   = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] last_idx;
   logic [2:0]       bsel_ff, bsel_in;

   logic [SAMPLE_W-1:0] yi_ff, yi_in, yq_ff, yq_in;

   // distance pipe: read, difference, square, sum
   logic             v_rd_ff, v_di_ff, v_sq_ff, v_sum_ff;
   logic [IDX_W-1:0] j_rd_ff, j_di_ff, j_sq_ff, j_sum_ff;
   logic [31:0]      ram_rdata;
   logic signed [16:0] di_in, dq_in, di_ff, dq_ff;
   logic signed [33:0] pi, pq;
   logic [31:0]      sqi_ff, sqq_ff;
   logic [DIST_W-1:0] d_ff;
   logic [LBL_W-1:0] label;
   logic             pipe_busy;

   logic [DIST_W-1:0] min0_ff [8];
   logic [DIST_W-1:0] min1_ff [8];
   logic [DIST_W-1:0] min0_in [8];
   logic [DIST_W-1:0] min1_in [8];
   logic [7:0]       has0_ff, has0_in, has1_ff, has1_in;

   // LLR pipe
   logic             en;
   logic             issue;
   logic             s1_v_ff, s2_v_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic             s1_h0_ff, s1_h1_ff, s2_h0_ff, s2_h1_ff;
   logic [2:0]       s1_pos_ff, s2_pos_ff;
   logic             s1_last_ff, s2_last_ff;
   logic signed [PROD_W-9:0] sh;
   logic [LLR_W-1:0] sat;

   logic ram_we;

   assign last_idx = (11'(cfg.npts_m1) < 11'(MAX_POINTS - 1)) ?
                     IDX_W'(cfg.npts_m1) : IDX_W'(MAX_POINTS - 1);

   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid;
   assign ram_we    = cmd_take && !cmd.is_demap;
   assign pipe_busy = v_rd_ff || v_di_ff || v_sq_ff || v_sum_ff;
   assign en        = !rsp_full;
   assign issue     = (state_ff == ST_LLR) && en;

   qllr_ram #(
      .WIDTH (32),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (IDX_W'(cmd.point_index)),
      .wdata ({cmd.quadrature, cmd.in_phase}),
      .raddr (j_ff),
      .rdata (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      bsel_in  = bsel_ff;
      yi_in    = yi_ff;
      yq_in    = yq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_take && cmd.is_demap) begin
               yi_in    = cmd.in_phase;
               yq_in    = cmd.quadrature;
               j_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (j_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               bsel_in  = '0;
               state_in = ST_LLR;
            end
         end
         ST_LLR: begin
            if (en) begin
               if (bsel_ff == cfg.nb_m1) begin
                  state_in = ST_IDLE;
               end else begin
                  bsel_in = bsel_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sample minus point, Q3.13
   assign di_in = $signed({yi_ff[15], yi_ff}) - $signed({ram_rdata[15], ram_rdata[15:0]});
   assign dq_in = $signed({yq_ff[15], yq_ff}) - $signed({ram_rdata[31], ram_rdata[31:16]});
   assign pi    = di_ff * di_ff;
   assign pq    = dq_ff * dq_ff;
   assign label = LBL_W'(j_sum_ff);

   // per-bit minimum tracking
   always_comb begin
      has0_in = has0_ff;
      has1_in = has1_ff;
      for (int b = 0; b < 8; b++) begin
         min0_in[b] = min0_ff[b];
         min1_in[b] = min1_ff[b];
      end
      if (cmd_take && cmd.is_demap) begin
         has0_in = '0;
         has1_in = '0;
      end else if (v_sum_ff) begin
         for (int b = 0; b < 8; b++) begin
            if (label[b]) begin
               if (!has1_ff[b] || (d_ff < min1_ff[b])) begin
                  min1_in[b] = d_ff;
                  has1_in[b] = 1'b1;
               end
            end else begin
               if (!has0_ff[b] || (d_ff < min0_ff[b])) begin
                  min0_in[b] = d_ff;
                  has0_in[b] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         v_rd_ff    <= 1'b0;
         v_di_ff    <= 1'b0;
         v_sq_ff    <= 1'b0;
         v_sum_ff   <= 1'b0;
         has0_ff    <= '0;
         has1_ff    <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         v_rd_ff    <= (state_ff == ST_SCAN);
         v_di_ff    <= v_rd_ff;
         v_sq_ff    <= v_di_ff;
         v_sum_ff   <= v_sq_ff;
         has0_ff    <= has0_in;
         has1_ff    <= has1_in;
         if (en) begin
            s1_v_ff <= issue;
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      bsel_ff  <= bsel_in;
      yi_ff    <= yi_in;
      yq_ff    <= yq_in;
      j_rd_ff  <= j_ff;
      j_di_ff  <= j_rd_ff;
      j_sq_ff  <= j_di_ff;
      j_sum_ff <= j_sq_ff;
      di_ff    <= di_in;
      dq_ff    <= dq_in;
      sqi_ff   <= pi[31:0];
      sqq_ff   <= pq[31:0];
      d_ff     <= {1'b0, sqi_ff} + {1'b0, sqq_ff};
      for (int b = 0; b < 8; b++) begin
         min0_ff[b] <= min0_in[b];
         min1_ff[b] <= min1_in[b];
      end
      if (en) begin
         diff_ff    <= $signed({1'b0, min1_ff[bsel_ff]}) - $signed({1'b0, min0_ff[bsel_ff]});
         s1_h0_ff   <= has0_ff[bsel_ff];
         s1_h1_ff   <= has1_ff[bsel_ff];
         s1_pos_ff  <= bsel_ff;
         s1_last_ff <= (bsel_ff == cfg.nb_m1);
         prod_ff    <= diff_ff * $signed({1'b0, cfg.noise_scale});
         s2_h0_ff   <= s1_h0_ff;
         s2_h1_ff   <= s1_h1_ff;
         s2_pos_ff  <= s1_pos_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // floor divide by 256, then saturate to 32 bits
   assign sh = prod_ff[PROD_W-1:8];

   always_comb begin
      if (!sh[PROD_W-9] && (|sh[PROD_W-10:LLR_W-1])) begin
         sat = LLR_POS_SAT;
      end else if (sh[PROD_W-9] && !(&sh[PROD_W-10:LLR_W-1])) begin
         sat = LLR_NEG_SAT;
      end else begin
         sat = sh[LLR_W-1:0];
      end
   end

   always_comb begin
      if (s2_h0_ff && s2_h1_ff) begin
         rsp.llr = sat;
      end else if (s2_h0_ff) begin
         rsp.llr = LLR_POS_SAT;
      end else if (s2_h1_ff) begin
         rsp.llr = LLR_NEG_SAT;
      end else begin
         rsp.llr = '0;
      end
   end

   assign rsp.bit_position = s2_pos_ff;
   assign rsp.last         = s2_last_ff;
   assign rsp_push         = s2_v_ff && en;

endmodule

`default_nettype wire

FILE: rtl/core/qam_maxlog_llr_demapper_unit.sv
// Max-log soft demapper for square QAM.
// Requests enter through a queue port: push with full, one request per edge
// where push is high and full low. req_op selects a table load (write the
// Q2.13 point req_in_phase/req_quadrature at label req_point_index) or a
// symbol demap. Loads give no response; a load past the table is dropped.
// A demap returns one response per label bit, LSB first, through a queue
// port: the head sits on rsp_* while empty is low and leaves on pop.
// rsp_last marks the final bit of a symbol.
// The back end takes a request only while idle; the scan reads one point
// per cycle from the table port, and a load is written as it is taken.
// The front holds two requests and the response queue four, so each side
// stalls on its own; a full response queue freezes the LLR stages and
// pushes back through to full. The user writes registers (csr_we,
// csr_index, csr_wdata) only while idle; the block does not enforce it.
// Synchronous reset empties both queues and sets bits_per_symbol to 4 and
// noise_scale to 1.0; the point table keeps its contents and must be loaded.
`timescale 1ns / 1ps
`default_nettype none

module qam_maxlog_llr_demapper_unit import qllr_pkg::*; #(
   parameter int MAX_POINTS = QLLR_MAX_POINTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request queue
   input  wire logic                  push,
   output logic                       full,
   input  wire logic                  req_op,
   input  wire logic [7:0]            req_point_index,
   input  wire logic [SAMPLE_W-1:0]   req_in_phase,
   input  wire logic [SAMPLE_W-1:0]   req_quadrature,
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // response queue
   output logic                       empty,
   input  wire logic                  pop,
   output logic      [LLR_W-1:0]      rsp_llr,
   output logic      [2:0]            rsp_bit_position,
   output logic                       rsp_last
);

   logic         cmd_valid;
   logic         cmd_take;
   qllr_cmd_type cmd;
   qllr_cfg_type cfg;
   logic         rsp_full;
   logic         rsp_push;
   qllr_rsp_type rsp_new;
   logic [$bits(qllr_rsp_type)-1:0] rsp_bits;
   qllr_rsp_type rsp_head;

   // front: registers, request classification, command queue
   qllr_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_in_phase    (req_in_phase),
      .req_quadrature  (req_quadrature),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take),
      .cfg             (cfg)
   );

   // back: point table, distance scan, LLR scaling
   qllr_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .cfg       (cfg),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   // response queue decouples the receiver from the LLR stages
   qllr_fifo #(
      .WIDTH ($bits(qllr_rsp_type)),
      .DEPTH (QLLR_RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_new),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_bits),
      .empty (empty)
   );

   assign rsp_head         = qllr_rsp_type'(rsp_bits);
   assign rsp_llr          = rsp_head.llr;
   assign rsp_bit_position = rsp_head.bit_position;
   assign rsp_last         = rsp_head.last;

endmodule

`default_nettype wire

FILE: rtl/core/qllr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module qllr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [31:0] rsp_llr,
   input wire logic [2:0]  rsp_bit_position,
   input wire logic        rsp_last
);

   // both queues come up empty
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // head response holds while not taken
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_llr) &&
                            $stable(rsp_bit_position) && $stable(rsp_last)))
      else $error("response changed while stalled");

   // bits of one symbol come in order
   assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_last) |=>
         (empty || (rsp_bit_position == $past(rsp_bit_position) + 3'd1)))
      else $error("bit position out of order");

   // a new symbol starts at bit zero
   assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && rsp_last) |=> (empty || (rsp_bit_position == 3'd0)))
      else $error("symbol does not start at bit zero");

   // at least two bits per symbol
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last) |-> (rsp_bit_position != 3'd0))
      else $error("symbol ended on bit zero");

endmodule

bind qam_maxlog_llr_demapper_unit qllr_checker u_qllr_checker (
   .clock            (clock),
   .reset            (reset),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_llr          (rsp_llr),
   .rsp_bit_position (rsp_bit_position),
   .rsp_last         (rsp_last)
);

`default_nettype wire

FILE: tb/sv/qam_maxlog_llr_demapper_unit_test.sv
`timescale 1ns / 1ps

module qam_maxlog_llr_demapper_unit_test;
   import qllr_pkg::*;

   // ------------------------------------------------------------------
   // Expected-LLR tracker: mirrors the point table and both registers,
   // works out the LLRs of every accepted demap request, and checks each
   // popped response against the oldest one still waiting.
   // ------------------------------------------------------------------
   class llr_tracker;
      logic [31:0]   points [256];
      bit            written [256];
      logic [3:0]    bps_raw;
      logic [15:0]   scale;
      qllr_rsp_type  pending_llrs [$];
      int unsigned   mismatches;

      function new();
         bps_raw     = BPS_RESET;
         scale       = NOISE_RESET;
         mismatches  = 0;
         foreach (written[k]) written[k] = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_BITS_PER_SYMBOL) bps_raw = data[3:0];
         else if (idx == CSR_NOISE_SCALE) scale = data;
      endfunction

      // register value as the datapath uses it: clamped to 2 .. 8
      function int unsigned label_bits();
         if (bps_raw < BPS_MIN) return BPS_MIN;
         if (bps_raw > BPS_MAX) return BPS_MAX;
         return bps_raw;
      endfunction

      function void note_request(logic op, logic [7:0] idx,
                                 logic [15:0] yi, logic [15:0] yq);
         int unsigned  nb;
         longint       di, dq, sq_dist, prod, r;
         longint       best0 [8], best1 [8];
         bit           seen0 [8], seen1 [8];
         logic [31:0]  llr;
         qllr_rsp_type next_llr;
         if (op == OP_LOAD) begin
            points[idx]  = {yq, yi};
            written[idx] = 1'b1;
            return;
         end
         nb = label_bits();
         for (int b = 0; b < 8; b++) begin
            seen0[b] = 1'b0;
            seen1[b] = 1'b0;
            best0[b] = 0;
            best1[b] = 0;
         end
         for (int j = 0; j < (1 << nb); j++) begin
            di      = longint'($signed(yi)) - longint'($signed(points[j][15:0]));
            dq      = longint'($signed(yq)) - longint'($signed(points[j][31:16]));
            sq_dist = di * di + dq * dq;
            for (int b = 0; b < nb; b++) begin
               if (((j >> b) & 1) == 0) begin
                  if (!seen0[b] || sq_dist < best0[b]) begin
                     best0[b] = sq_dist;
                     seen0[b] = 1'b1;
                  end
               end else begin
                  if (!seen1[b] || sq_dist < best1[b]) begin
                     best1[b] = sq_dist;
                     seen1[b] = 1'b1;
                  end
               end
            end
         end
         for (int b = 0; b < nb; b++) begin
            if (seen0[b] && seen1[b]) begin
               prod = (best1[b] - best0[b]) * longint'(scale);
               r    = prod >>> 8;   // floor division by 256
               if (r > 64'sd2147483647)       llr = LLR_POS_SAT;
               else if (r < -64'sd2147483648) llr = LLR_NEG_SAT;
               else                           llr = r[31:0];
            end else if (seen0[b]) llr = LLR_POS_SAT;
            else if (seen1[b])     llr = LLR_NEG_SAT;
            else                   llr = '0;
            next_llr     = qllr_rsp_type'{llr, b[2:0], (b + 1 == nb)};
            pending_llrs = {pending_llrs, next_llr};
         end
      endfunction

      function void check_response(logic [31:0] llr, logic [2:0] pos, logic last);
         qllr_rsp_type want;
         if (pending_llrs.size() == 0) begin
            $display("%0t: response with none expected: llr %0d pos %0d last %0d",
                     $time, $signed(llr), pos, last);
            mismatches++;
            return;
         end
         want = pending_llrs.pop_front();
         if (want.llr !== llr) begin
            $display("%0t: llr expected %0d actual %0d", $time,
                     $signed(want.llr), $signed(llr));
            mismatches++;
         end
         if (want.bit_position !== pos) begin
            $display("%0t: bit_position expected %0d actual %0d", $time,
                     want.bit_position, pos);
            mismatches++;
         end
         if (want.last !== last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_op;
   logic [7:0]            req_point_index;
   logic [SAMPLE_W-1:0]   req_in_phase;
   logic [SAMPLE_W-1:0]   req_quadrature;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  empty;
   logic                  pop;
   logic [LLR_W-1:0]      rsp_llr;
   logic [2:0]            rsp_bit_position;
   logic                  rsp_last;

   llr_tracker tracker = new();

   // per-phase switches: when set, that side runs flat out with no gaps
   bit req_steady;
   bit rsp_steady;

   // longest symbol (256 points) plus pipeline, in cycles
   localparam int DRAIN_CYCLES = 300;

   qam_maxlog_llr_demapper_unit uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_op           (req_op),
      .req_point_index  (req_point_index),
      .req_in_phase     (req_in_phase),
      .req_quadrature   (req_quadrature),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .empty            (empty),
      .pop              (pop),
      .rsp_llr          (rsp_llr),
      .rsp_bit_position (rsp_bit_position),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run (all 8-bit symbols
   // with long response stalls would still finish well inside this).
   initial begin
      #8_000_000;
      $display("qam_maxlog_llr_demapper_unit: mismatch");
      $finish;
   end

   // Mostly back-to-back, some short gaps, the odd long one.
   function automatic int unsigned pick_gap(bit steady);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] clamp16(int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // ------------------------------------------------------------------
   // Request side. Every task starts and ends on a rising edge. push is
   // left high when the next request follows at once, so it is never
   // dropped and raised within one step.
   // ------------------------------------------------------------------
   task automatic push_request(logic op, logic [7:0] idx, logic [15:0] yi, logic [15:0] yq);
      int unsigned gap;
      push            <= 1'b1;
      req_op          <= op;
      req_point_index <= idx;
      req_in_phase    <= yi;
      req_quadrature  <= yq;
      // full is read before the edge's updates land, i.e. the value the
      // queue used to accept or refuse the request at this edge
      do @(posedge clock); while (full);
      tracker.note_request(op, idx, yi, yq);
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop push, wait for every outstanding LLR, then give loads and the
   // back end time to go quiet before touching the registers.
   task automatic settle();
      push <= 1'b0;
      do @(posedge clock); while (tracker.pending_llrs.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both registers, one after the other; the unused top bits of the
   // bits-per-symbol write carry junk half the time.
   task automatic apply_settings(logic [3:0] bps, logic [15:0] scale);
      logic [15:0] bps_word;
      bps_word = {($urandom_range(0, 1) ? 12'($urandom) : 12'h000), bps};
      csr_we    <= 1'b1;
      csr_index <= CSR_BITS_PER_SYMBOL;
      csr_wdata <= bps_word;
      @(posedge clock);
      tracker.set_register(CSR_BITS_PER_SYMBOL, bps_word);
      csr_index <= CSR_NOISE_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      tracker.set_register(CSR_NOISE_SCALE, scale);
      csr_we <= 1'b0;
   endtask

   // Load labels 0 .. 2^nb-1: a square grid when nb is even and asked
   // for, random points otherwise. With refill_only set, only labels
   // never written are loaded (used for the big tables).
   task automatic load_table(int unsigned nb, bit grid, bit refill_only);
      int unsigned levels, half, stride;
      int          li, lq;
      half   = nb / 2;
      levels = 1 << half;
      stride = 30720 / (levels - 1);
      for (int j = 0; j < (1 << nb); j++) begin
         if (refill_only && tracker.written[j]) continue;
         if (grid && nb % 2 == 0) begin
            li = (2 * int'(j & (levels - 1)) - int'(levels - 1)) * int'(stride);
            lq = (2 * int'(j >> half) - int'(levels - 1)) * int'(stride);
            push_request(OP_LOAD, j[7:0], li[15:0], lq[15:0]);
         end else
            push_request(OP_LOAD, j[7:0], 16'($urandom), 16'($urandom));
      end
   endtask

   // A received symbol: mostly a table point plus noise of random reach,
   // sometimes anywhere at all.
   task automatic demap_symbol(int unsigned nb);
      int unsigned j, spread;
      int          yi, yq;
      if ($urandom_range(0, 4) == 0) begin
         push_request(OP_DEMAP, 8'($urandom), 16'($urandom), 16'($urandom));
         return;
      end
      j = $urandom_range(0, (1 << nb) - 1);
      case ($urandom_range(0, 3))
         0: spread = 0;
         1: spread = 64;
         2: spread = 2048;
         default: spread = 16384;
      endcase
      yi = int'($signed(tracker.points[j][15:0])) + int'($urandom_range(0, 2 * spread))
           - int'(spread);
      yq = int'($signed(tracker.points[j][31:16])) + int'($urandom_range(0, 2 * spread))
           - int'(spread);
      push_request(OP_DEMAP, 8'($urandom), clamp16(yi), clamp16(yq));
   endtask

   // ------------------------------------------------------------------
   // Response side: pop with random stalls, check each popped LLR.
   // ------------------------------------------------------------------
   initial begin
      int unsigned gap;
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = pick_gap(rsp_steady);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         tracker.check_response(rsp_llr, rsp_bit_position, rsp_last);
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [3:0]  bps_plan [12];
      int          scale_plan [12];
      logic [15:0] scale;
      int unsigned nb, count;

      // raw bits-per-symbol writes: both clamp ends, odd sizes, extremes
      bps_plan   = '{4'd2, 4'd4, 4'd6, 4'd3, 4'd0, 4'd5,
                     4'd8, 4'd1, 4'd7, 4'd15, 4'd9, 4'd4};
      // noise scale per phase; -1 picks a random one
      scale_plan = '{-1, 0, 65535, -1, 1, -1,
                     65535, 256, -1, 65535, -1, 256};

      reset           <= 1'b1;
      push            <= 1'b0;
      req_op          <= OP_LOAD;
      req_point_index <= '0;
      req_in_phase    <= '0;
      req_quadrature  <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_BITS_PER_SYMBOL;
      csr_wdata       <= '0;
      req_steady      = 1'b0;
      rsp_steady      = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset settings (16 points, unit noise scale) ---
      load_table(4, 1'b1, 1'b0);
      // top label holds the most negative I and most positive Q
      push_request(OP_LOAD, 8'd255, 16'h8000, 16'h7FFF);
      // exact grid point, origin, both corners
      push_request(OP_DEMAP, 8'd0, tracker.points[5][15:0], tracker.points[5][31:16]);
      push_request(OP_DEMAP, 8'd0, 16'h0000, 16'h0000);
      push_request(OP_DEMAP, 8'd255, 16'h7FFF, 16'h7FFF);
      push_request(OP_DEMAP, 8'd1, 16'h8000, 16'h8000);
      // label 0 pushed to the far corner, then probed from the opposite one
      push_request(OP_LOAD, 8'd0, 16'h8000, 16'h8000);
      push_request(OP_DEMAP, 8'd0, 16'h7FFF, 16'h7FFF);
      push_request(OP_DEMAP, 8'd0, 16'h8000, 16'h7FFF);
      settle();

      // --- random phases, each with its own register settings ---
      foreach (bps_plan[p]) begin
         scale = (scale_plan[p] < 0) ? 16'($urandom) : scale_plan[p][15:0];
         apply_settings(bps_plan[p], scale);
         nb = tracker.label_bits();
         req_steady = (p % 4 == 1);
         rsp_steady = (p % 4 == 2);

         // tables of up to 8 points are reloaded in full; larger ones are
         // only filled where empty, plus a couple of fresh points
         if (nb <= 3)
            load_table(nb, $urandom_range(0, 1), 1'b0);
         else begin
            load_table(nb, 1'b0, 1'b1);
            repeat (2)
               push_request(OP_LOAD, 8'($urandom_range(0, (1 << nb) - 1)),
                            16'($urandom), 16'($urandom));
         end

         count = (nb == 8) ? 2 : 3;
         repeat (count) begin
            // the odd point load mixed in among symbols, any label
            if ($urandom_range(0, 9) == 0)
               push_request(OP_LOAD, 8'($urandom), 16'($urandom), 16'($urandom));
            demap_symbol(nb);
         end
         // sender holds off until every LLR of this phase is back
         settle();
      end

      if (tracker.mismatches == 0)
         $display("qam_maxlog_llr_demapper_unit: match");
      else
         $display("qam_maxlog_llr_demapper_unit: mismatch");
      $finish;
   end

endmodule
